// ===== rtl/ffba_pkg.sv =====
package ffba_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int POOL_BYTES   = 2097152;
  localparam int ALIGN_BYTES  = 16;
  localparam int HEADER_BYTES = 32;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = IDX_W + 1;
  localparam int OFS_W = 21;
  localparam int REQ_SIZE_W = 22;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [REQ_SIZE_W-1:0] req_size;
    logic [OFS_W-1:0]      req_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFS_W-1:0] result_addr;
    logic [OFS_W-1:0] used_bytes;
    logic [OFS_W-1:0] free_bytes;
    logic [6:0]       block_count;
    logic [31:0]      alloc_count;
    logic [31:0]      release_count;
  } rsp_t;

  typedef struct packed {
    logic [OFS_W-1:0] start;
    logic [OFS_W-1:0] size;
    logic             free;
  } seg_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SHUP_RD, S_SHUP_WR, S_SPLIT_WR,
    S_ALLOC_WR, S_NXT_RD, S_NXT_CHK, S_SHDN_RD, S_SHDN_WR, S_CUR_WR,
    S_PRV_RD, S_PRV_CHK, S_FINISH
  } state_t;

endpackage

// ===== rtl/first_fit_block_allocator.sv =====
// First-fit pool allocator. The segment table sits in one 64-entry RAM with a
// registered read port; every step reads one entry, then acts on it in the next
// cycle. A request reads the table entries in order until one fits or matches,
// then shifts entries up to open a slot on a split or down on each merge; an
// ignored request skips the scan. One request is in work at a time. After reset
// the init state writes the initial whole-pool segment before the first request
// is taken.
module first_fit_block_allocator (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ffba_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_ready,
  output ffba_pkg::rsp_t out_rsp
);

  localparam int IW = ffba_pkg::IDX_W;
  localparam int CW = ffba_pkg::CNT_W;
  localparam int OW = ffba_pkg::OFS_W;
  localparam logic [OW-1:0] HDR = OW'(ffba_pkg::HEADER_BYTES);
  localparam logic [OW-1:0] SPLIT_MIN = OW'(ffba_pkg::HEADER_BYTES + ffba_pkg::ALIGN_BYTES);
  localparam logic [CW-1:0] MAXB = CW'(ffba_pkg::MAX_BLOCKS);
  localparam int AW = ffba_pkg::REQ_SIZE_W + 1;
  localparam logic [AW-1:0] ALIGN_MASK = AW'(ffba_pkg::ALIGN_BYTES - 1);

  // segment table RAM
  ffba_pkg::seg_t mem [ffba_pkg::MAX_BLOCKS];
  logic            we;
  logic [IW-1:0]   wa, ra;
  ffba_pkg::seg_t  wd, rd_q;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  ffba_pkg::state_t state_r, state_nxt;
  ffba_pkg::req_t   req_r, req_nxt;
  ffba_pkg::seg_t   cur_r, cur_nxt;
  ffba_pkg::rsp_t   out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CW-1:0]    idx_r, idx_nxt, hit_r, hit_nxt, k_r, k_nxt, total_r, total_nxt;
  logic [OW-1:0]    used_r, used_nxt, free_r, free_nxt, addr_r, addr_nxt;
  logic [31:0]      acnt_r, acnt_nxt, rcnt_r, rcnt_nxt;
  logic [1:0]       st_r, st_nxt;
  logic             phase_r, phase_nxt;
  ffba_pkg::seg_t   split_r, split_nxt;

  logic [AW-1:0] aligned;
  logic [OW-1:0] rem;
  logic          fit, owns, do_split;

  // round up the request and test the entry just read
  always_comb begin
    aligned  = ({1'b0, req_r.req_size} + ALIGN_MASK) & ~ALIGN_MASK;
    fit      = rd_q.free && ({2'b0, rd_q.size} >= aligned);
    rem      = rd_q.size - aligned[OW-1:0];
    owns     = !rd_q.free && ({1'b0, rd_q.start} + {1'b0, HDR} == {1'b0, req_r.req_addr});
    do_split = (rem > SPLIT_MIN) && (total_r < MAXB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffba_pkg::S_INIT;
      out_valid_r <= 1'b0;
      total_r     <= CW'(1);
      used_r      <= '0;
      free_r      <= OW'(ffba_pkg::POOL_BYTES - ffba_pkg::HEADER_BYTES);
      acnt_r      <= '0;
      rcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
      used_r      <= used_nxt;
      free_r      <= free_nxt;
      acnt_r      <= acnt_nxt;
      rcnt_r      <= rcnt_nxt;
    end
    req_r   <= req_nxt;
    cur_r   <= cur_nxt;
    out_r   <= out_nxt;
    idx_r   <= idx_nxt;
    hit_r   <= hit_nxt;
    k_r     <= k_nxt;
    addr_r  <= addr_nxt;
    st_r    <= st_nxt;
    phase_r <= phase_nxt;
    split_r <= split_nxt;
  end

  // sequencer: scan, shift and merge
  always_comb begin
    state_nxt = state_r;     req_nxt = req_r;     cur_nxt = cur_r;
    out_nxt = out_r;         out_valid_nxt = out_valid_r;
    idx_nxt = idx_r;         hit_nxt = hit_r;     k_nxt = k_r;
    total_nxt = total_r;     used_nxt = used_r;   free_nxt = free_r;
    acnt_nxt = acnt_r;       rcnt_nxt = rcnt_r;   addr_nxt = addr_r;
    st_nxt = st_r;           phase_nxt = phase_r; split_nxt = split_r;
    we = 1'b0;  wa = '0;  wd = '0;  ra = idx_r[IW-1:0];
    in_ready = 1'b0;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ffba_pkg::S_INIT: begin
        we = 1'b1;
        wa = '0;
        wd = '{start: '0, size: OW'(ffba_pkg::POOL_BYTES - ffba_pkg::HEADER_BYTES), free: 1'b1};
        state_nxt = ffba_pkg::S_IDLE;
      end
      ffba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt  = in_req;
          idx_nxt  = '0;
          addr_nxt = '0;
          if ((in_req.req_type == ffba_pkg::REQ_ALLOC && in_req.req_size == '0) ||
              (in_req.req_type == ffba_pkg::REQ_FREE && in_req.req_addr == '0)) begin
            st_nxt    = ffba_pkg::ST_IGNORED;
            state_nxt = ffba_pkg::S_FINISH;
          end else begin
            state_nxt = ffba_pkg::S_SCAN_RD;
          end
        end
      end
      ffba_pkg::S_SCAN_RD: begin
        ra = idx_r[IW-1:0];
        state_nxt = ffba_pkg::S_SCAN_CHK;
      end
      ffba_pkg::S_SCAN_CHK: begin
        hit_nxt = idx_r;
        if (req_r.req_type == ffba_pkg::REQ_ALLOC && fit) begin
          st_nxt   = ffba_pkg::ST_OK;
          addr_nxt = rd_q.start + HDR;
          acnt_nxt = acnt_r + 32'd1;
          cur_nxt  = rd_q;
          cur_nxt.free = 1'b0;
          if (do_split) begin
            cur_nxt.size = aligned[OW-1:0];
            used_nxt = used_r + aligned[OW-1:0];
            free_nxt = free_r - aligned[OW-1:0];
            split_nxt = '{start: rd_q.start + HDR + aligned[OW-1:0],
                          size: rem - HDR, free: 1'b1};
            k_nxt = total_r - CW'(1);
            state_nxt = (total_r - CW'(1) >= idx_r + CW'(1)) ? ffba_pkg::S_SHUP_RD
                                                               : ffba_pkg::S_SPLIT_WR;
          end else begin
            used_nxt = used_r + rd_q.size;
            free_nxt = free_r - rd_q.size;
            state_nxt = ffba_pkg::S_ALLOC_WR;
          end
        end else if (req_r.req_type == ffba_pkg::REQ_FREE && owns) begin
          st_nxt   = ffba_pkg::ST_OK;
          used_nxt = used_r - rd_q.size;
          free_nxt = free_r + rd_q.size;
          rcnt_nxt = rcnt_r + 32'd1;
          cur_nxt  = rd_q;
          cur_nxt.free = 1'b1;
          state_nxt = (idx_r + CW'(1) < total_r) ? ffba_pkg::S_NXT_RD : ffba_pkg::S_CUR_WR;
        end else if (idx_r + CW'(1) == total_r) begin
          st_nxt = (req_r.req_type == ffba_pkg::REQ_ALLOC) ? ffba_pkg::ST_OOM
                                                           : ffba_pkg::ST_BADFREE;
          state_nxt = ffba_pkg::S_FINISH;
        end else begin
          idx_nxt = idx_r + CW'(1);
          state_nxt = ffba_pkg::S_SCAN_RD;
        end
      end
      // open a slot after the hit entry
      ffba_pkg::S_SHUP_RD: begin
        ra = k_r[IW-1:0];
        state_nxt = ffba_pkg::S_SHUP_WR;
      end
      ffba_pkg::S_SHUP_WR: begin
        we = 1'b1;
        wa = IW'(k_r + CW'(1));
        wd = rd_q;
        k_nxt = k_r - CW'(1);
        state_nxt = (k_r == hit_r + CW'(1)) ? ffba_pkg::S_SPLIT_WR : ffba_pkg::S_SHUP_RD;
      end
      ffba_pkg::S_SPLIT_WR: begin
        we = 1'b1;
        wa = IW'(hit_r + CW'(1));
        wd = split_r;
        total_nxt = total_r + CW'(1);
        state_nxt = ffba_pkg::S_ALLOC_WR;
      end
      ffba_pkg::S_ALLOC_WR: begin
        we = 1'b1;
        wa = hit_r[IW-1:0];
        wd = cur_r;
        state_nxt = ffba_pkg::S_FINISH;
      end
      // merge with the next neighbor
      ffba_pkg::S_NXT_RD: begin
        ra = IW'(hit_r + CW'(1));
        state_nxt = ffba_pkg::S_NXT_CHK;
      end
      ffba_pkg::S_NXT_CHK: begin
        if (rd_q.free) begin
          cur_nxt.size = cur_r.size + HDR + rd_q.size;
          phase_nxt = 1'b0;
          k_nxt = hit_r + CW'(2);
          if (hit_r + CW'(2) < total_r) begin
            state_nxt = ffba_pkg::S_SHDN_RD;
          end else begin
            total_nxt = total_r - CW'(1);
            state_nxt = ffba_pkg::S_CUR_WR;
          end
        end else begin
          state_nxt = ffba_pkg::S_CUR_WR;
        end
      end
      // close the gap left by a removed entry
      ffba_pkg::S_SHDN_RD: begin
        ra = k_r[IW-1:0];
        state_nxt = ffba_pkg::S_SHDN_WR;
      end
      ffba_pkg::S_SHDN_WR: begin
        we = 1'b1;
        wa = IW'(k_r - CW'(1));
        wd = rd_q;
        k_nxt = k_r + CW'(1);
        if (k_r + CW'(1) == total_r) begin
          total_nxt = total_r - CW'(1);
          state_nxt = phase_r ? ffba_pkg::S_FINISH : ffba_pkg::S_CUR_WR;
        end else begin
          state_nxt = ffba_pkg::S_SHDN_RD;
        end
      end
      ffba_pkg::S_CUR_WR: begin
        we = 1'b1;
        wa = hit_r[IW-1:0];
        wd = cur_r;
        state_nxt = (hit_r != '0) ? ffba_pkg::S_PRV_RD : ffba_pkg::S_FINISH;
      end
      // merge with the previous neighbor
      ffba_pkg::S_PRV_RD: begin
        ra = IW'(hit_r - CW'(1));
        state_nxt = ffba_pkg::S_PRV_CHK;
      end
      ffba_pkg::S_PRV_CHK: begin
        if (rd_q.free) begin
          we = 1'b1;
          wa = IW'(hit_r - CW'(1));
          wd = rd_q;
          wd.size = rd_q.size + HDR + cur_r.size;
          phase_nxt = 1'b1;
          k_nxt = hit_r + CW'(1);
          if (hit_r + CW'(1) < total_r) begin
            state_nxt = ffba_pkg::S_SHDN_RD;
          end else begin
            total_nxt = total_r - CW'(1);
            state_nxt = ffba_pkg::S_FINISH;
          end
        end else begin
          state_nxt = ffba_pkg::S_FINISH;
        end
      end
      // hand the result over once the output slot is open
      ffba_pkg::S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{status: st_r, result_addr: addr_r, used_bytes: used_r,
                      free_bytes: free_r, block_count: 7'(total_r),
                      alloc_count: acnt_r, release_count: rcnt_r};
          state_nxt = ffba_pkg::S_IDLE;
        end
      end
      default: state_nxt = ffba_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    total_r != '0 && total_r <= MAXB)
    else $error("segment count out of range");

  a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ffba_pkg::S_SPLIT_WR |-> total_r < MAXB)
    else $error("split into a full table");

  a_grant_addr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ffba_pkg::S_FINISH && st_r == ffba_pkg::ST_OK &&
    req_r.req_type == ffba_pkg::REQ_ALLOC |-> addr_r >= HDR)
    else $error("granted offset inside first header");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

endmodule

// ===== tb/first_fit_block_allocator_tb.sv =====
`timescale 1ns / 1ps

module first_fit_block_allocator_tb;

  localparam int  CLK_PERIOD  = 12;
  localparam int  CYCLE_LIMIT = 3000000;
  localparam int  RANDOM_REQS = 900;
  localparam int  OFS_W       = ffba_pkg::OFS_W;
  localparam int  REQ_SIZE_W  = ffba_pkg::REQ_SIZE_W;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  ffba_pkg::req_t in_req;
  logic out_valid;
  logic out_ready;
  ffba_pkg::rsp_t out_rsp;

  first_fit_block_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  // Mirror of the segment table and statistics
  longint      seg_start [ffba_pkg::MAX_BLOCKS];
  longint      seg_size  [ffba_pkg::MAX_BLOCKS];
  bit          seg_free  [ffba_pkg::MAX_BLOCKS];
  int          seg_n;
  longint      used_sum;
  longint      free_sum;
  logic [31:0] grant_tally;
  logic [31:0] return_tally;

  ffba_pkg::rsp_t expected_rsp_q[$];
  int          live_addrs[$];
  int          error_count;
  int          cycle_count;
  int          burst_left;
  int          status_seen [4];
  int          max_segments;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses pending", cycle_count,
               expected_rsp_q.size());
      $display("[first_fit_block_allocator] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  task automatic drop_segment(input int idx);
    int k;
    for (k = idx; k + 1 < seg_n; k++) begin
      seg_start[k] = seg_start[k+1];
      seg_size[k]  = seg_size[k+1];
      seg_free[k]  = seg_free[k+1];
    end
    seg_n--;
  endtask

  // Compute the response of one request and advance the mirror
  task automatic predict_allocator(input ffba_pkg::req_t r, output ffba_pkg::rsp_t e);
    longint     aligned;
    longint     rem;
    longint     grant;
    int         i;
    int         k;
    logic [1:0] st;
    grant = 0;
    if (r.req_type == ffba_pkg::REQ_ALLOC) begin
      if (r.req_size == 0) begin
        st = ffba_pkg::ST_IGNORED;
      end else begin
        aligned = ((longint'(r.req_size) + ffba_pkg::ALIGN_BYTES - 1) / ffba_pkg::ALIGN_BYTES)
                  * ffba_pkg::ALIGN_BYTES;
        for (i = 0; i < seg_n; i++)
          if (seg_free[i] && seg_size[i] >= aligned) break;
        if (i >= seg_n) begin
          st = ffba_pkg::ST_OOM;
        end else begin
          rem = seg_size[i] - aligned;
          // Split off the tail if it is large enough and the table is not full
          if (rem > ffba_pkg::HEADER_BYTES + ffba_pkg::ALIGN_BYTES &&
              seg_n < ffba_pkg::MAX_BLOCKS) begin
            for (k = seg_n; k > i + 1; k--) begin
              seg_start[k] = seg_start[k-1];
              seg_size[k]  = seg_size[k-1];
              seg_free[k]  = seg_free[k-1];
            end
            seg_start[i+1] = seg_start[i] + ffba_pkg::HEADER_BYTES + aligned;
            seg_size[i+1]  = rem - ffba_pkg::HEADER_BYTES;
            seg_free[i+1]  = 1'b1;
            seg_size[i]    = aligned;
            seg_n++;
          end
          seg_free[i] = 1'b0;
          used_sum += seg_size[i];
          free_sum -= seg_size[i];
          grant_tally++;
          grant = seg_start[i] + ffba_pkg::HEADER_BYTES;
          live_addrs.push_back(int'(grant));
          st = ffba_pkg::ST_OK;
        end
      end
    end else begin
      if (r.req_addr == 0) begin
        st = ffba_pkg::ST_IGNORED;
      end else begin
        for (i = 0; i < seg_n; i++)
          if (!seg_free[i] && seg_start[i] + ffba_pkg::HEADER_BYTES == r.req_addr) break;
        if (i >= seg_n) begin
          st = ffba_pkg::ST_BADFREE;
        end else begin
          used_sum -= seg_size[i];
          free_sum += seg_size[i];
          return_tally++;
          seg_free[i] = 1'b1;
          // Merge with next, then previous free neighbor
          if (i + 1 < seg_n && seg_free[i+1]) begin
            seg_size[i] += ffba_pkg::HEADER_BYTES + seg_size[i+1];
            drop_segment(i + 1);
          end
          if (i > 0 && seg_free[i-1]) begin
            seg_size[i-1] += ffba_pkg::HEADER_BYTES + seg_size[i];
            drop_segment(i);
          end
          for (k = 0; k < live_addrs.size(); k++)
            if (live_addrs[k] == int'(r.req_addr)) begin
              live_addrs.delete(k);
              break;
            end
          st = ffba_pkg::ST_OK;
        end
      end
    end
    if (seg_n > max_segments) max_segments = seg_n;
    e.status        = st;
    e.result_addr   = grant[OFS_W-1:0];
    e.used_bytes    = used_sum[OFS_W-1:0];
    e.free_bytes    = free_sum[OFS_W-1:0];
    e.block_count   = seg_n[6:0];
    e.alloc_count   = grant_tally;
    e.release_count = return_tally;
  endtask

  // Send one request in bursts with random gaps; predict on acceptance
  task automatic send_request(input ffba_pkg::req_t r);
    ffba_pkg::rsp_t e;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    predict_allocator(r, e);
    expected_rsp_q.push_back(e);
  endtask

  task automatic send_alloc(input int unsigned size);
    ffba_pkg::req_t r;
    r.req_type = ffba_pkg::REQ_ALLOC;
    r.req_size = size[REQ_SIZE_W-1:0];
    r.req_addr = OFS_W'($urandom());
    send_request(r);
  endtask

  task automatic send_free(input int unsigned addr);
    ffba_pkg::req_t r;
    r.req_type = ffba_pkg::REQ_FREE;
    r.req_size = REQ_SIZE_W'($urandom());
    r.req_addr = addr[OFS_W-1:0];
    send_request(r);
  endtask

  task automatic release_all_live();
    int idx;
    while (live_addrs.size() > 0) begin
      idx = $urandom_range(0, live_addrs.size() - 1);
      send_free(live_addrs[idx]);
    end
  endtask

  // Ignored requests, bad frees and double frees
  task automatic test_special_cases();
    int a;
    send_alloc(0);
    send_free(0);
    send_free(32'd2097151);
    send_free(ffba_pkg::HEADER_BYTES);
    send_alloc(1);
    a = live_addrs[0];
    send_alloc(16);
    send_alloc(17);
    send_free(a + 16);
    send_free(a);
    send_free(a);
    release_all_live();
  endtask

  // Whole-pool grants, out of memory, split threshold
  task automatic test_whole_pool();
    send_alloc(ffba_pkg::POOL_BYTES - ffba_pkg::HEADER_BYTES);
    send_alloc(1);
    release_all_live();
    send_alloc(ffba_pkg::POOL_BYTES);
    send_alloc(32'h3FFFFF);
    send_alloc(ffba_pkg::POOL_BYTES - ffba_pkg::HEADER_BYTES - 48);
    release_all_live();
    send_alloc(ffba_pkg::POOL_BYTES - ffba_pkg::HEADER_BYTES - 64);
    send_alloc(ffba_pkg::POOL_BYTES - ffba_pkg::HEADER_BYTES - 63);
    release_all_live();
  endtask

  // Fill the table so that splits are skipped, then coalesce everything
  task automatic test_table_full();
    repeat (ffba_pkg::MAX_BLOCKS + 4) send_alloc($urandom_range(1, 48));
    release_all_live();
  endtask

  // Mostly legal alloc/free traffic with some noise
  task automatic test_random_traffic();
    int pick;
    int unsigned size;
    repeat (RANDOM_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 52 || live_addrs.size() == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      size = $urandom_range(1, 512);
        else if (pick < 90) size = $urandom_range(513, 65536);
        else if (pick < 98) size = $urandom_range(65537, 600000);
        else                size = $urandom_range(0, 32'h3FFFFF);
        send_alloc(size);
      end else if (pick < 92) begin
        send_free(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
      end else if (pick < 96) begin
        send_free($urandom_range(0, 32'h1FFFFF));
      end else if (pick < 98) begin
        send_alloc(0);
      end else begin
        send_free(0);
      end
    end
    release_all_live();
  endtask

  // Receiver stall pattern: stretches of always-ready and of random stalls
  int stall_phase;
  always @(posedge clk) begin
    if (stall_phase == 0) stall_phase <= $urandom_range(1, 400);
    else stall_phase <= stall_phase - 1;
    if (stall_phase > 200) out_ready <= 1'b1;
    else if (stall_phase > 100) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= ($urandom_range(0, 5) < 2);
  end

  // Check each accepted response against the oldest expectation
  always @(posedge clk) begin
    ffba_pkg::rsp_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("unexpected response", 1, 0);
      end else begin
        e = expected_rsp_q.pop_front();
        status_seen[e.status]++;
        if (out_rsp.status !== e.status)
          report_mismatch("status", out_rsp.status, e.status);
        if (out_rsp.result_addr !== e.result_addr)
          report_mismatch("result_addr", out_rsp.result_addr, e.result_addr);
        if (out_rsp.used_bytes !== e.used_bytes)
          report_mismatch("used_bytes", out_rsp.used_bytes, e.used_bytes);
        if (out_rsp.free_bytes !== e.free_bytes)
          report_mismatch("free_bytes", out_rsp.free_bytes, e.free_bytes);
        if (out_rsp.block_count !== e.block_count)
          report_mismatch("block_count", out_rsp.block_count, e.block_count);
        if (out_rsp.alloc_count !== e.alloc_count)
          report_mismatch("alloc_count", out_rsp.alloc_count, e.alloc_count);
        if (out_rsp.release_count !== e.release_count)
          report_mismatch("release_count", out_rsp.release_count, e.release_count);
      end
    end
  end

  initial begin
    int drain;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req       = '0;
    out_ready    = 1'b0;
    stall_phase  = 0;
    cycle_count  = 0;
    error_count  = 0;
    burst_left   = 0;
    seg_start[0] = 0;
    seg_size[0]  = ffba_pkg::POOL_BYTES - ffba_pkg::HEADER_BYTES;
    seg_free[0]  = 1'b1;
    seg_n        = 1;
    used_sum     = 0;
    free_sum     = ffba_pkg::POOL_BYTES - ffba_pkg::HEADER_BYTES;
    grant_tally  = '0;
    return_tally = '0;
    max_segments = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_special_cases();
    test_whole_pool();
    test_table_full();
    test_random_traffic();
    in_valid <= 1'b0;

    // Drain outstanding responses, then let the block settle
    while (expected_rsp_q.size() > 0) @(posedge clk);
    drain = 0;
    while (drain < 8 * ffba_pkg::MAX_BLOCKS) begin
      @(posedge clk);
      drain++;
    end

    $display("covered %0d grants, %0d frees, %0d out-of-memory, %0d ignored, %0d bad frees",
             status_seen[ffba_pkg::ST_OK] - int'(return_tally), return_tally,
             status_seen[ffba_pkg::ST_OOM], status_seen[ffba_pkg::ST_IGNORED],
             status_seen[ffba_pkg::ST_BADFREE]);
    $display("table peaked at %0d segments over %0d cycles", max_segments, cycle_count);
    if (error_count == 0) begin
      $display("[first_fit_block_allocator] OK");
    end else begin
      $display("[first_fit_block_allocator] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ffba_pkg.sv
rtl/first_fit_block_allocator.sv
tb/first_fit_block_allocator_tb.sv
